### hdl/wtmt_pkg.sv
`timescale 1ns / 1ps
// Package for the window trimmed mean trigger: sizes, state types and the
// request/response structs between the top level and the merge engine.
// No dependencies.
package wtmt_pkg;

    localparam int WINDOW = 30;
    localparam int CUT    = WINDOW / 4;
    localparam int KEEP   = WINDOW - 2 * CUT;
    localparam int SMP_W  = 10;
    localparam int MRG_W  = 11;
    localparam int IDX_W  = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = SMP_W + $clog2(KEEP) + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_WAIT
    } t_top_state;

    typedef enum logic [1:0] {
        M_IDLE,
        M_RUN,
        M_DONE
    } t_mrg_state;

    typedef struct packed {
        logic             start;
        logic             remove;
        logic [SMP_W-1:0] x;
        logic [SMP_W-1:0] v;
        logic [CNT_W-1:0] src_len;
    } t_mrg_req;

    typedef struct packed {
        logic             done;
        logic [SMP_W-1:0] avg;
    } t_mrg_rsp;

endpackage

### hdl/wtmt_if.sv
`timescale 1ns / 1ps
// Channel interfaces: sample input, result output and margin write.
// Depends on wtmt_pkg.
interface wtmt_in_if import wtmt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [SMP_W-1:0] sample;
    logic             sample_ok;

    modport source (output valid, output sample, output sample_ok, input ready);
    modport sink   (input valid, input sample, input sample_ok, output ready);
endinterface

interface wtmt_out_if import wtmt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             trigger;
    logic [SMP_W-1:0] average;
    logic             window_full;
    logic             stopped;

    modport source (output valid, output trigger, output average, output window_full,
                    output stopped, input ready);
    modport sink   (input valid, input trigger, input average, input window_full,
                    input stopped, output ready);
endinterface

interface wtmt_cfg_if import wtmt_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [MRG_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hdl/wtmt_merge.sv
`timescale 1ns / 1ps
// Sorted-window merge engine: streams the sorted copy through one compare
// unit, drops the evicted value, inserts the new one and sums the middle ranks.
// Depends on wtmt_pkg.
module wtmt_merge import wtmt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mrg_req i_req,
    output t_mrg_rsp o_rsp
);

    logic [SMP_W-1:0] mem_a [WINDOW];
    logic [SMP_W-1:0] mem_b [WINDOW];
    logic [SMP_W-1:0] r_rd_a, r_rd_b;

    t_mrg_state       r_state, n_state;
    logic             r_bank, n_bank;
    logic [CNT_W-1:0] r_k, n_k;
    logic [CNT_W-1:0] r_w, n_w;
    logic             r_ins, n_ins;
    logic             r_rem, n_rem;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic             r_remove;
    logic [SMP_W-1:0] r_x, r_v;
    logic [CNT_W-1:0] r_src_len, r_out_len;

    logic [SMP_W-1:0] head;
    logic             have, skip, take_x, in_mid, we;
    logic [SMP_W-1:0] emit_val;
    logic [IDX_W-1:0] rd_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_bank  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_bank  <= n_bank;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k   <= n_k;
        r_w   <= n_w;
        r_ins <= n_ins;
        r_rem <= n_rem;
        r_sum <= n_sum;
        if (r_state == M_IDLE && i_req.start) begin
            r_remove  <= i_req.remove;
            r_x       <= i_req.x;
            r_v       <= i_req.v;
            r_src_len <= i_req.src_len;
            r_out_len <= i_req.remove ? i_req.src_len : CNT_W'(i_req.src_len + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (we && r_bank) begin
            mem_a[r_w[IDX_W-1:0]] <= emit_val;
        end
        if (we && !r_bank) begin
            mem_b[r_w[IDX_W-1:0]] <= emit_val;
        end
        r_rd_a <= mem_a[rd_addr];
        r_rd_b <= mem_b[rd_addr];
    end

    always_comb begin
        head     = r_bank ? r_rd_b : r_rd_a;
        have     = r_k < r_src_len;
        skip     = r_remove && !r_rem && have && (head == r_v);
        take_x   = !skip && !r_ins && (!have || (r_x <= head));
        emit_val = take_x ? r_x : head;
        in_mid   = (r_w >= CNT_W'(CUT)) && (r_w < CNT_W'(WINDOW - CUT));

        n_state = r_state;
        n_bank  = r_bank;
        n_k     = r_k;
        n_w     = r_w;
        n_ins   = r_ins;
        n_rem   = r_rem;
        n_sum   = r_sum;
        we      = 1'b0;
        o_rsp   = '{done: 1'b0, avg: SMP_W'(r_sum / KEEP)};

        unique case (r_state)
            M_IDLE: begin
                if (i_req.start) begin
                    n_k     = '0;
                    n_w     = '0;
                    n_ins   = 1'b0;
                    n_rem   = 1'b0;
                    n_sum   = '0;
                    n_state = M_RUN;
                end
            end
            M_RUN: begin
                if (skip) begin
                    n_rem = 1'b1;
                    n_k   = CNT_W'(r_k + 1'b1);
                end else begin
                    we  = 1'b1;
                    n_w = CNT_W'(r_w + 1'b1);
                    if (take_x) begin
                        n_ins = 1'b1;
                    end else begin
                        n_k = CNT_W'(r_k + 1'b1);
                    end
                    if (in_mid) begin
                        n_sum = SUM_W'(r_sum + emit_val);
                    end
                    if (n_w == r_out_len) begin
                        n_state = M_DONE;
                    end
                end
            end
            M_DONE: begin
                o_rsp.done = 1'b1;
                n_bank     = ~r_bank;
                n_state    = M_IDLE;
            end
            default: n_state = M_IDLE;
        endcase

        rd_addr = (r_state == M_RUN && n_k < CNT_W'(WINDOW)) ? n_k[IDX_W-1:0] : '0;
    end

endmodule

### hdl/window_trimmed_mean_trigger.sv
`timescale 1ns / 1ps
// Top level of the window trimmed mean trigger: handshakes, sample ring,
// fill/halt control and result register. Depends on wtmt_pkg, wtmt_if, wtmt_merge.
//
//  channel  | dir | beat fields
//  ---------+-----+---------------------------------------------
//  i_in     | in  | sample[9:0], sample_ok
//  o_out    | out | trigger, average[9:0], window_full, stopped
//  i_cfg    | in  | data[10:0] (margin, signed)
//
// Ignored, halted and triggering beats finish in the accept cycle.
// A beat that updates the window holds off the next accept until the merge pass,
// which streams the sorted copy through one compare unit, is done.
// Reset clears fill count, average, halt flag and margin; no clearing pass.
// A waiting result stalls input until it is taken or taken in the same cycle.
module window_trimmed_mean_trigger import wtmt_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    wtmt_in_if.sink      i_in,
    wtmt_out_if.source   o_out,
    wtmt_cfg_if.sink     i_cfg
);

    logic [SMP_W-1:0] ring [WINDOW];

    t_top_state              r_state, n_state;
    logic [CNT_W-1:0]        r_fill, n_fill;
    logic [IDX_W-1:0]        r_oldest, n_oldest;
    logic [SMP_W-1:0]        r_avg, n_avg;
    logic                    r_halted, n_halted;
    logic signed [MRG_W-1:0] r_margin;
    logic                    r_out_valid, n_out_valid;
    logic                    r_out_trig, n_out_trig;
    logic [SMP_W-1:0]        r_out_avg, n_out_avg;
    logic                    r_out_full, n_out_full;
    logic                    r_out_stop, n_out_stop;
    logic [SMP_W-1:0]        r_x;
    logic [SMP_W-1:0]        r_old;
    logic                    r_remove;
    logic [CNT_W-1:0]        r_src_len;

    logic                    in_acc, full, trig, work, ring_we;
    logic [IDX_W-1:0]        ring_addr;
    logic signed [MRG_W:0]   diff;
    t_mrg_req                req;
    t_mrg_rsp                rsp;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign in_acc      = i_in.valid && i_in.ready;

    assign o_out.valid       = r_out_valid;
    assign o_out.trigger     = r_out_trig;
    assign o_out.average     = r_out_avg;
    assign o_out.window_full = r_out_full;
    assign o_out.stopped     = r_out_stop;

    assign full      = (r_fill == CNT_W'(WINDOW));
    assign diff      = $signed({2'b00, r_avg}) - $signed({2'b00, i_in.sample});
    assign trig      = diff >= $signed({r_margin[MRG_W-1], r_margin});
    assign work      = i_in.sample_ok && !r_halted && (!full || !trig);
    assign ring_we   = in_acc && work;
    assign ring_addr = full ? r_oldest : r_fill[IDX_W-1:0];

    assign req = '{start: (r_state == S_START), remove: r_remove, x: r_x, v: r_old,
                   src_len: r_src_len};

    wtmt_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            ring[ring_addr] <= i_in.sample;
            r_old           <= ring[r_oldest];
            r_x             <= i_in.sample;
            r_remove        <= full;
            r_src_len       <= full ? CNT_W'(WINDOW) : r_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_oldest    <= '0;
            r_avg       <= '0;
            r_halted    <= 1'b0;
            r_margin    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_oldest    <= n_oldest;
            r_avg       <= n_avg;
            r_halted    <= n_halted;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                r_margin <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_trig <= n_out_trig;
        r_out_avg  <= n_out_avg;
        r_out_full <= n_out_full;
        r_out_stop <= n_out_stop;
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_oldest    = r_oldest;
        n_avg       = r_avg;
        n_halted    = r_halted;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_trig  = r_out_trig;
        n_out_avg   = r_out_avg;
        n_out_full  = r_out_full;
        n_out_stop  = r_out_stop;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (work) begin
                        if (!full) begin
                            n_fill = CNT_W'(r_fill + 1'b1);
                        end
                        n_state = S_START;
                    end else begin
                        // hold state; report it, raising the trigger on a drop
                        n_out_valid = 1'b1;
                        n_out_trig  = i_in.sample_ok && !r_halted && full && trig;
                        n_halted    = r_halted || n_out_trig;
                        n_out_avg   = r_avg;
                        n_out_full  = full;
                        n_out_stop  = n_halted;
                    end
                end
            end
            S_START: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (rsp.done) begin
                    if (r_remove) begin
                        n_avg    = rsp.avg;
                        n_oldest = (r_oldest == IDX_W'(WINDOW - 1)) ? '0
                                 : IDX_W'(r_oldest + 1'b1);
                    end else if (full) begin
                        n_avg    = rsp.avg;
                        n_oldest = '0;
                    end
                    n_out_valid = 1'b1;
                    n_out_trig  = 1'b0;
                    n_out_avg   = n_avg;
                    n_out_full  = full;
                    n_out_stop  = r_halted;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !i_in.ready)
        else $error("input ready while a window update is in flight");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(WINDOW))
        else $error("fill count beyond window size");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.done |-> (r_state == S_WAIT))
        else $error("merge done outside wait state");

    a_halt_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halt flag dropped");

    a_halt_no_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_halted && r_state == S_IDLE) |=> (r_state == S_IDLE))
        else $error("window update started after halt");

endmodule
